// ===== rtl/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// Shared constants and types of the double-ended queue core.
// ----------------------------------------------------------------------------
package deq_pkg;

  // Default sizing
  localparam int unsigned DefCapacity  = 256;
  localparam int unsigned DefDataWidth = 32;

  // Fixed field widths of the stream payload
  localparam int unsigned OpW      = 3;
  localparam int unsigned ElemW    = 32;
  localparam int unsigned PosW     = 8;
  localparam int unsigned RdataW   = 32;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned LenW     = 9;
  localparam int unsigned InTdataW  = 48;
  localparam int unsigned OutTdataW = 48;

  // Operation codes
  localparam logic [OpW-1:0] OpPushFront = 3'd0;
  localparam logic [OpW-1:0] OpPushBack  = 3'd1;
  localparam logic [OpW-1:0] OpPopFront  = 3'd2;
  localparam logic [OpW-1:0] OpPopBack   = 3'd3;
  localparam logic [OpW-1:0] OpGet       = 3'd4;
  localparam logic [OpW-1:0] OpSet       = 3'd5;

  // Status codes
  localparam logic [StatusW-1:0] StOk    = 2'd0;
  localparam logic [StatusW-1:0] StEmpty = 2'd1;
  localparam logic [StatusW-1:0] StFull  = 2'd2;
  localparam logic [StatusW-1:0] StRange = 2'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // register the incoming transaction
    logic execute;  // perform the registered operation
  } deq_cmd_t;

endpackage

// ===== rtl/deq_ctrl.sv =====
// ----------------------------------------------------------------------------
// deq_ctrl
// Sequencer: accept one transaction, execute it, present the result.
// ----------------------------------------------------------------------------
module deq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output deq_pkg::deq_cmd_t cmd_o
);
  import deq_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StExec = 2'd1;
  localparam logic [1:0] StResp = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_valid_i) state_d = StExec;
      StExec: state_d = StResp;
      StResp: if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o    = (state_q == StIdle);
  assign out_valid_o   = (state_q == StResp);
  assign cmd_o.capture = in_valid_i && (state_q == StIdle);
  assign cmd_o.execute = (state_q == StExec);

endmodule

// ===== rtl/deq_datapath.sv =====
// ----------------------------------------------------------------------------
// deq_datapath
// Ring store, front pointer, occupancy count and result registers.
// ----------------------------------------------------------------------------
module deq_datapath #(
  parameter int unsigned CAPACITY   = deq_pkg::DefCapacity,
  parameter int unsigned DATA_WIDTH = deq_pkg::DefDataWidth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  deq_pkg::deq_cmd_t            cmd_i,
  input  logic [deq_pkg::OpW-1:0]      opcode_i,
  input  logic [deq_pkg::ElemW-1:0]    element_i,
  input  logic [deq_pkg::PosW-1:0]     position_i,
  output logic [deq_pkg::RdataW-1:0]   read_data_o,
  output logic [deq_pkg::StatusW-1:0]  status_o,
  output logic [deq_pkg::LenW-1:0]     length_o
);
  import deq_pkg::*;

  localparam int unsigned PW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned SW   = PW + 1;
  localparam int unsigned CMPW = (CW > PosW) ? CW : PosW;
  localparam logic [SW-1:0] CapS    = SW'(CAPACITY);
  localparam logic [CW-1:0] CapC    = CW'(CAPACITY);
  localparam logic [PW-1:0] LastIdx = PW'(CAPACITY - 1);

  // Registered transaction
  logic [OpW-1:0]   op_q;
  logic [ElemW-1:0] elem_q;
  logic [PosW-1:0]  pos_q;

  // Queue state
  logic [PW-1:0] front_q, front_d;
  logic [CW-1:0] occ_q, occ_d;

  // Result
  logic [StatusW-1:0]    status_q, status_d;
  logic [LenW-1:0]       len_q;
  logic                  rsel_q, rsel_d;
  logic [DATA_WIDTH-1:0] rdata_q;

  // Memory access
  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic                  we, re;
  logic [PW-1:0]         addr;

  logic          full, empty, range_bad;
  logic [SW-1:0] offset, sum;
  logic [PW-1:0] slot, front_dec;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= opcode_i;
      elem_q <= element_i;
      pos_q  <= position_i;
    end
  end

  assign full      = (occ_q == CapC);
  assign empty     = (occ_q == '0);
  assign range_bad = (CMPW'(pos_q) >= CMPW'(occ_q));

  // Offset from the front: the entry touched, or the new front for pop front
  always_comb begin
    unique case (op_q)
      OpPushBack: offset = SW'(occ_q);
      OpPopBack:  offset = SW'(occ_q - 1'b1);
      OpPopFront: offset = SW'(1);
      default:    offset = SW'(pos_q);
    endcase
  end

  // Wrap the ring index with one compare and subtract
  assign sum       = SW'(front_q) + offset;
  assign slot      = (sum >= CapS) ? PW'(sum - CapS) : PW'(sum);
  assign front_dec = (front_q == '0) ? LastIdx : front_q - 1'b1;

  always_comb begin
    front_d  = front_q;
    occ_d    = occ_q;
    status_d = StOk;
    rsel_d   = 1'b0;
    we       = 1'b0;
    re       = 1'b0;
    addr     = slot;
    unique case (op_q)
      OpPushFront: begin
        if (full) begin
          status_d = StFull;
        end else begin
          front_d = front_dec;
          occ_d   = occ_q + 1'b1;
          we      = 1'b1;
          addr    = front_dec;
        end
      end
      OpPushBack: begin
        if (full) begin
          status_d = StFull;
        end else begin
          occ_d = occ_q + 1'b1;
          we    = 1'b1;
        end
      end
      OpPopFront: begin
        if (empty) begin
          status_d = StEmpty;
        end else begin
          front_d = slot;
          occ_d   = occ_q - 1'b1;
          re      = 1'b1;
          rsel_d  = 1'b1;
          addr    = front_q;
        end
      end
      OpPopBack: begin
        if (empty) begin
          status_d = StEmpty;
        end else begin
          occ_d  = occ_q - 1'b1;
          re     = 1'b1;
          rsel_d = 1'b1;
        end
      end
      OpGet: begin
        if (range_bad) begin
          status_d = StRange;
        end else begin
          re     = 1'b1;
          rsel_d = 1'b1;
        end
      end
      OpSet: begin
        if (range_bad) begin
          status_d = StRange;
        end else begin
          we = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      occ_q   <= '0;
    end else if (cmd_i.execute) begin
      front_q <= front_d;
      occ_q   <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      status_q <= status_d;
      len_q    <= LenW'(occ_d);
      rsel_q   <= rsel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute && we) begin
      mem[addr] <= DATA_WIDTH'(elem_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute && re) begin
      rdata_q <= mem[addr];
    end
  end

  assign read_data_o = rsel_q ? RdataW'(rdata_q) : '0;
  assign status_o    = status_q;
  assign length_o    = len_q;

endmodule

// ===== rtl/double_ended_queue_core.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Bounded double-ended queue on a ring buffer of CAPACITY entries.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one operation per transaction: push front, push
//   back, pop front, pop back, get by position or set by position. The master
//   stream returns exactly one result transaction for each: the popped or
//   read element (zero otherwise), a status (ok, empty, full, out of range)
//   and the number of elements held after the operation.
//   Timing: an accepted transaction is executed in the next cycle, and its
//   result is presented on the cycle after that. One operation is in
//   flight at a time: the sequencer steps through its accept, execute and
//   result states for each transaction before it accepts the next one.
//   Reset clears the front pointer and the occupancy; the store itself is
//   not cleared, and only written entries are ever read.
//   When the receiver stalls, the result holds on the master stream and the
//   slave stream stays not ready until the result is taken.
//   A rejected operation (full, empty, out of range) leaves all state as is.
// ----------------------------------------------------------------------------
module double_ended_queue_core #(
  parameter int unsigned CAPACITY   = deq_pkg::DefCapacity,
  parameter int unsigned DATA_WIDTH = deq_pkg::DefDataWidth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Operation stream
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [2:0] opcode, [34:3] element, [42:35] position, [47:43] zero
  input  logic [deq_pkg::InTdataW-1:0]   s_axis_tdata_i,
  // Result stream
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [31:0] read_data, [33:32] status, [42:34] length, [47:43] zero
  output logic [deq_pkg::OutTdataW-1:0]  m_axis_tdata_o
);
  import deq_pkg::*;

  deq_cmd_t            cmd;
  logic [RdataW-1:0]   read_data;
  logic [StatusW-1:0]  status;
  logic [LenW-1:0]     length;

  // Sequence accept, execute and result handshake
  deq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd)
  );

  // Hold the ring, pointers and the result registers
  deq_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .opcode_i    (s_axis_tdata_i[OpW-1:0]),
    .element_i   (s_axis_tdata_i[OpW+ElemW-1:OpW]),
    .position_i  (s_axis_tdata_i[OpW+ElemW+PosW-1:OpW+ElemW]),
    .read_data_o (read_data),
    .status_o    (status),
    .length_o    (length)
  );

  // Pack the result, pad with zeros to whole bytes
  assign m_axis_tdata_o = {{(OutTdataW - RdataW - StatusW - LenW){1'b0}},
                           length, status, read_data};

endmodule

// ===== test/double_ended_queue_checker.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_checker
// Watches both streams of the queue core, predicts each result from its own
// model of the ring and compares the returned transactions in order.
// ----------------------------------------------------------------------------
module double_ended_queue_checker
  import deq_pkg::*;
#(
  parameter int unsigned CAPACITY   = DefCapacity,
  parameter int unsigned DATA_WIDTH = DefDataWidth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 op_valid_i,
  input  logic                 op_ready_i,
  input  logic [InTdataW-1:0]  op_data_i,
  input  logic                 res_valid_i,
  input  logic                 res_ready_i,
  input  logic [OutTdataW-1:0] res_data_i,
  output int unsigned          fail_count_o,
  output int unsigned          awaited_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam logic [ElemW-1:0] ElemMask =
    (DATA_WIDTH >= ElemW) ? '1 : ElemW'((64'd1 << DATA_WIDTH) - 64'd1);

  typedef struct packed {
    logic [OpW-1:0]     op;
    logic [RdataW-1:0]  rdata;
    logic [StatusW-1:0] status;
    logic [LenW-1:0]    len;
  } deq_reply_t;

  logic [ElemW-1:0] ring_mem [CAPACITY];
  int unsigned      ring_front = 0;
  int unsigned      ring_count = 0;
  deq_reply_t       replies_q[$];

  // Apply one operation to the model ring and return the reply it produces.
  function automatic deq_reply_t apply_deq_op(input logic [OpW-1:0]   op,
                                              input logic [ElemW-1:0] elem,
                                              input logic [PosW-1:0]  pos);
    deq_reply_t r;
    r.op     = op;
    r.rdata  = '0;
    r.status = StOk;
    case (op)
      OpPushFront: begin
        if (ring_count >= CAPACITY) begin
          r.status = StFull;
        end else begin
          ring_front = (ring_front + CAPACITY - 1) % CAPACITY;
          ring_mem[IdxW'(ring_front)] = elem & ElemMask;
          ring_count++;
        end
      end
      OpPushBack: begin
        if (ring_count >= CAPACITY) begin
          r.status = StFull;
        end else begin
          ring_mem[IdxW'((ring_front + ring_count) % CAPACITY)] = elem & ElemMask;
          ring_count++;
        end
      end
      OpPopFront: begin
        if (ring_count == 0) begin
          r.status = StEmpty;
        end else begin
          r.rdata = RdataW'(ring_mem[IdxW'(ring_front)]);
          ring_front = (ring_front + 1) % CAPACITY;
          ring_count--;
        end
      end
      OpPopBack: begin
        if (ring_count == 0) begin
          r.status = StEmpty;
        end else begin
          ring_count--;
          r.rdata = RdataW'(ring_mem[IdxW'((ring_front + ring_count) % CAPACITY)]);
        end
      end
      OpGet: begin
        if (pos >= ring_count) begin
          r.status = StRange;
        end else begin
          r.rdata = RdataW'(ring_mem[IdxW'((ring_front + pos) % CAPACITY)]);
        end
      end
      OpSet: begin
        if (pos >= ring_count) begin
          r.status = StRange;
        end else begin
          ring_mem[IdxW'((ring_front + pos) % CAPACITY)] = elem & ElemMask;
        end
      end
      default: begin
        // spare opcodes change nothing
      end
    endcase
    r.len = LenW'(ring_count);
    return r;
  endfunction

  // Sample both channels on the edge; a result is never taken on the edge that
  // accepts its operation, so check before recording the new one.
  always @(posedge clk_i) begin
    deq_reply_t want;
    deq_reply_t got;
    if (rst_ni) begin
      if (res_valid_i && res_ready_i) begin
        got.op     = '0;
        got.rdata  = res_data_i[RdataW-1:0];
        got.status = res_data_i[RdataW +: StatusW];
        got.len    = res_data_i[RdataW+StatusW +: LenW];
        if (replies_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) begin
            $display("%0t: unexpected result: data %h status %0d length %0d",
                     $realtime, got.rdata, got.status, got.len);
          end
        end else begin
          want = replies_q.pop_front();
          if (got.rdata !== want.rdata || got.status !== want.status ||
              got.len !== want.len) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("%0t: op %0d expected %h/%0d/%0d got %h/%0d/%0d",
                       $realtime, want.op, want.rdata, want.status, want.len,
                       got.rdata, got.status, got.len);
            end
          end
        end
      end
      if (op_valid_i && op_ready_i) begin
        replies_q.push_back(apply_deq_op(op_data_i[OpW-1:0],
                                         op_data_i[OpW +: ElemW],
                                         op_data_i[OpW+ElemW +: PosW]));
      end
    end
    awaited_o = replies_q.size();
  end

endmodule

// ===== test/double_ended_queue_core_tb.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_core_tb
// Drives directed and random deque operations into the core with random
// bursts on the operation stream and back-pressure on the result stream;
// a checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module double_ended_queue_core_tb;

  import deq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAP        = DefCapacity;
  localparam int unsigned RandItems  = 1400;
  localparam int unsigned CycleLimit = 400000;

  // Opcodes the core treats as no operation
  localparam logic [OpW-1:0] OpSpareLo = 3'd6;
  localparam logic [OpW-1:0] OpSpareHi = 3'd7;

  typedef enum logic [1:0] {SeqFill, SeqDrain, SeqMix} seq_mode_e;
  typedef enum logic [1:0] {RxAlways, RxCoin, RxSparse, RxPeriodic} rx_mode_e;

  logic                 clk_i   = 1'b0;
  logic                 rst_ni  = 1'b0;
  logic                 s_valid = 1'b0;
  logic [InTdataW-1:0]  s_data  = '0;
  logic                 m_ready = 1'b0;
  logic                 s_ready;
  logic                 m_valid;
  logic [OutTdataW-1:0] m_data;

  int unsigned fail_count;
  int unsigned awaited;
  int unsigned cycles     = 0;
  int unsigned stim_occ   = 0;   // occupancy as the stimulus sees it
  int unsigned burst_left = 0;
  rx_mode_e    rx_mode    = RxAlways;
  int unsigned rx_left    = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  double_ended_queue_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  double_ended_queue_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_valid_i   (s_valid),
    .op_ready_i   (s_ready),
    .op_data_i    (s_data),
    .res_valid_i  (m_valid),
    .res_ready_i  (m_ready),
    .res_data_i   (m_data),
    .fail_count_o (fail_count),
    .awaited_o    (awaited)
  );

  // Receiver back-pressure: switch between always ready, coin flip, mostly
  // stalled and a fixed one-in-four pattern, each held for a random stretch.
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(16, 160);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RxAlways: m_ready <= 1'b1;
      RxCoin:   m_ready <= ($urandom_range(0, 1) == 0);
      RxSparse: m_ready <= ($urandom_range(0, 3) == 0);
      default:  m_ready <= (rx_left[1:0] == 2'b00);
    endcase
  end

  // Present one operation, hold it until the core takes the transaction,
  // then either keep the burst going or drop valid for a random gap.
  task automatic send_op(input logic [OpW-1:0]   op,
                         input logic [ElemW-1:0] elem,
                         input logic [PosW-1:0]  pos);
    int unsigned gap;
    s_valid <= 1'b1;
    s_data  <= {{(InTdataW-OpW-ElemW-PosW){1'b0}}, pos, elem, op};
    do @(posedge clk_i); while (!s_ready);
    // track occupancy so positions can be aimed inside the held range
    case (op)
      OpPushFront, OpPushBack: if (stim_occ < CAP) stim_occ++;
      OpPopFront, OpPopBack:   if (stim_occ > 0) stim_occ--;
      default: ;
    endcase
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(0, 24);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Watchdog: end the run with an error once CycleLimit cycles have passed.
  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    seq_mode_e         mode;
    seq_mode_e         mode_next;
    int unsigned       mix_left;
    int unsigned       roll;
    int unsigned       push_pct;
    int unsigned       pop_pct;
    logic [OpW-1:0]    op;
    logic [ElemW-1:0]  elem;
    logic [PosW-1:0]   pos;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: rejections on an empty queue, spare opcodes, field
    // extremes, a push to the front that wraps the pointer below zero,
    // reads and writes at both ends of the range and just past it.
    send_op(OpPopFront, '1, '1);
    send_op(OpPopBack,  '0, '0);
    send_op(OpGet,      '0, '0);
    send_op(OpSet,      '1, '0);
    send_op(OpSpareLo,  '1, '1);
    send_op(OpSpareHi,  '0, '0);
    send_op(OpPushBack,  32'hFFFF_FFFF, 8'd0);
    send_op(OpPushFront, 32'h0000_0000, 8'd0);
    send_op(OpPushBack,  32'hA5A5_5A5A, 8'd0);
    send_op(OpPushFront, 32'h8000_0001, 8'd0);
    send_op(OpGet, '0, 8'd0);
    send_op(OpGet, '0, 8'd3);
    send_op(OpGet, '0, 8'd4);
    send_op(OpGet, '0, 8'd255);
    send_op(OpSet, 32'h1234_5678, 8'd3);
    send_op(OpSet, 32'h5555_AAAA, 8'd255);
    send_op(OpSet, 32'hFFFF_FFFF, 8'd0);
    send_op(OpSpareHi, 32'hDEAD_BEEF, 8'd1);
    send_op(OpPopBack,  '0, '0);
    send_op(OpPopFront, '0, '0);
    send_op(OpGet, '0, 8'd1);
    send_op(OpPopFront, '0, '0);
    send_op(OpPopBack,  '0, '0);
    send_op(OpPopBack,  '0, '0);

    // Random part: alternate fill and drain sweeps with mixed stretches in
    // between, so both the full and the empty boundaries are crossed often.
    mode      = SeqFill;
    mode_next = SeqDrain;
    mix_left  = 0;
    for (int n = 0; n < RandItems; n++) begin
      case (mode)
        SeqFill:  begin push_pct = 80; pop_pct = 6;  end
        SeqDrain: begin push_pct = 8;  pop_pct = 72; end
        default:  begin push_pct = 25; pop_pct = 25; end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < push_pct) begin
        op = ($urandom_range(0, 1) == 0) ? OpPushFront : OpPushBack;
      end else if (roll < push_pct + pop_pct) begin
        op = ($urandom_range(0, 1) == 0) ? OpPopFront : OpPopBack;
      end else if (roll < 97) begin
        op = ($urandom_range(0, 1) == 0) ? OpGet : OpSet;
      end else begin
        op = ($urandom_range(0, 1) == 0) ? OpSpareLo : OpSpareHi;
      end

      roll = $urandom_range(0, 19);
      if (roll == 0) begin
        elem = '0;
      end else if (roll == 1) begin
        elem = '1;
      end else begin
        elem = $urandom;
      end

      // Aim most positions inside the held range, some at its edges and
      // some anywhere.
      roll = $urandom_range(0, 19);
      if (stim_occ == 0 || roll < 3) begin
        pos = PosW'($urandom_range(0, 255));
      end else if (roll == 3) begin
        pos = PosW'(stim_occ - 1);
      end else if (roll == 4) begin
        pos = (stim_occ < CAP) ? PosW'(stim_occ) : '1;
      end else begin
        pos = PosW'($urandom_range(0, stim_occ - 1));
      end

      send_op(op, elem, pos);

      case (mode)
        SeqFill: begin
          if (stim_occ == CAP && $urandom_range(0, 5) == 0) begin
            mode      = SeqMix;
            mode_next = SeqDrain;
            mix_left  = $urandom_range(40, 100);
          end
        end
        SeqDrain: begin
          if (stim_occ == 0 && $urandom_range(0, 5) == 0) begin
            mode      = SeqMix;
            mode_next = SeqFill;
            mix_left  = $urandom_range(40, 100);
          end
        end
        default: begin
          mix_left--;
          if (mix_left == 0) mode = mode_next;
        end
      endcase
    end
    s_valid <= 1'b0;

    // Wait out the remaining results, then keep watching for strays.
    @(negedge clk_i);
    while (awaited != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (fail_count == 0 && awaited == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/deq_pkg.sv
rtl/deq_ctrl.sv
rtl/deq_datapath.sv
rtl/double_ended_queue_core.sv
test/double_ended_queue_checker.sv
test/double_ended_queue_core_tb.sv
